>>> src/gasp_pkg.sv
package gasp_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_PLACED     = 2'd0,
		ST_LOAD_FAIL  = 2'd1,
		ST_NO_TEXTURE = 2'd2
	} status_t;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_PIXELS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TEX     = 3'd4;

	// Register reset values.
	localparam logic [15:0] RST_GLYPH_COUNT = 16'd256;
	localparam logic [9:0]  RST_CELL_WIDTH  = 10'd16;
	localparam logic [9:0]  RST_CELL_HEIGHT = 10'd16;
	localparam logic [7:0]  RST_PAD_PIXELS  = 8'd3;
	localparam logic [14:0] RST_MAX_TEX     = 15'd4096;

	// Smallest power of two that is >= x, with zero mapping to one.
	function automatic logic [15:0] pow2_ceil(input logic [14:0] x);
		logic [14:0] y;
		begin
			y = x - 15'd1;
			y = y | (y >> 1);
			y = y | (y >> 2);
			y = y | (y >> 4);
			y = y | (y >> 8);
			if (x == 15'd0) begin
				pow2_ceil = 16'd1;
			end else begin
				pow2_ceil = {1'b0, y} + 16'd1;
			end
		end
	endfunction

	// Texture edge: the smallest power of two not below v, limited to the maximum size.
	function automatic logic [14:0] clamp_size(input logic [27:0] v, input logic [14:0] mx);
		logic [15:0] p;
		begin
			p = pow2_ceil(v[14:0]);
			if (v > {13'd0, mx}) begin
				clamp_size = mx;
			end else if (p > {1'b0, mx}) begin
				clamp_size = mx;
			end else begin
				clamp_size = p[14:0];
			end
		end
	endfunction

endpackage

>>> src/glyph_atlas_shelf_packer_core.sv
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------------
// in       | input     | in_valid / in_stall | glyph_ok, glyph_box_width
// out      | output    | out_valid/out_stall | status, texture_index, x_position,
//          |           |                     | y_position, texture_width, texture_height,
//          |           |                     | new_texture
// cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A placed glyph passes through accept, evaluate, row check and result load;
// a failed load skips the row check. Opening a texture adds two multiplier
// passes, two clamps, two divider setups and two divider loops, and a first
// glyph may open two textures in turn. Reset restores the register
// defaults and empties the packer. in_stall is high while a request is in work;
// a finished result waits under out_stall while the next request is accepted.
module glyph_atlas_shelf_packer_core #(
	parameter int unsigned MAX_TEXTURES = 256
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        glyph_ok,
	input  logic [9:0]  glyph_box_width,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  texture_index,
	output logic [13:0] x_position,
	output logic [13:0] y_position,
	output logic [14:0] texture_width,
	output logic [14:0] texture_height,
	output logic        new_texture,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [gasp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	// Width of the open-texture counter, wide enough to hold MAX_TEXTURES itself.
	localparam int unsigned NT_W = $clog2(MAX_TEXTURES + 1);

	// The sequencer. The common path runs IDLE, EVAL, ROW, FINISH. Opening a texture
	// walks through the sizing states, which share one multiplier and one divider.
	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_ROW,
		S_MUL_W,
		S_CLAMP_W,
		S_DIV_INIT,
		S_DIV_COLS,
		S_NEXT_DIV,
		S_DIV_ROWS,
		S_MUL_H,
		S_CLAMP_H,
		S_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] glyph_count_q;
	logic [9:0]  cell_width_q;
	logic [9:0]  cell_height_q;
	logic [7:0]  pad_pixels_q;
	logic [14:0] max_tex_q;

	// Committed packer state.
	logic [14:0]     cursor_x_q;
	logic [14:0]     cursor_y_q;
	logic [NT_W-1:0] textures_open_q;
	logic [14:0]     current_width_q;
	logic [14:0]     current_height_q;
	logic [15:0]     remaining_q;

	// Working copy of the state for the request in flight.
	logic                ok_q;
	logic [9:0]          box_q;
	logic [14:0]         cx_q;
	logic [14:0]         cy_q;
	logic [NT_W-1:0]     nt_q;
	logic [14:0]         w_q;
	logic [14:0]         h_q;
	logic                opened_q;
	logic                first_q;
	gasp_pkg::status_t   stat_q;

	// Shared arithmetic: multiplier result register and divider registers.
	logic [27:0] v_q;
	logic [14:0] rem_q;
	logic [15:0] quo_q;
	logic [14:0] den_q;
	logic [3:0]  cnt_q;

	// Output register.
	logic                out_valid_q;
	gasp_pkg::status_t   status_q;
	logic [7:0]          texture_index_q;
	logic [13:0]         x_position_q;
	logic [13:0]         y_position_q;
	logic [14:0]         texture_width_q;
	logic [14:0]         texture_height_q;
	logic                new_texture_q;

	// The multiplier is shared between the width estimate (remaining glyphs
	// times cell width) and the height estimate (rows times cell height).
	logic [16:0] mul_a;
	logic [9:0]  mul_b;
	logic [26:0] mul_p;
	logic [8:0]  two_pad;

	assign two_pad = {pad_pixels_q, 1'b0};
	assign mul_a   = (state_q == S_MUL_H) ? ({1'b0, quo_q} + 17'd1) : {1'b0, remaining_q};
	assign mul_b   = (state_q == S_MUL_H) ? cell_height_q : cell_width_q;
	assign mul_p   = {10'd0, mul_a} * {17'd0, mul_b};

	// One restoring divider step: bring in the next dividend bit and subtract
	// the divisor when it fits.
	logic [15:0] div_cur;
	logic [15:0] div_diff;
	logic        div_ge;
	logic [14:0] rem_next;

	assign div_cur  = {rem_q, quo_q[15]};
	assign div_ge   = div_cur >= {1'b0, den_q};
	assign div_diff = div_cur - {1'b0, den_q};
	assign rem_next = div_ge ? div_diff[14:0] : div_cur[14:0];

	// Row and shelf checks on the working cursor. A row is closed once the
	// cursor has passed the last full cell; the cursor then drops one cell
	// height (saturating), and if that row no longer fits, the texture is full.
	logic [15:0] cx_reach;
	logic [15:0] cy_sum;
	logic [14:0] cy_next;
	logic [15:0] cy_reach;
	logic        row_full;
	logic        tex_full;
	logic        no_more_tex;

	assign cx_reach    = {1'b0, cx_q} + {6'd0, cell_width_q};
	assign row_full    = cx_reach > {1'b0, w_q};
	assign cy_sum      = {1'b0, cy_q} + {6'd0, cell_height_q};
	assign cy_next     = cy_sum[15] ? 15'h7FFF : cy_sum[14:0];
	assign cy_reach    = {1'b0, cy_next} + {6'd0, cell_height_q};
	assign tex_full    = cy_reach > {1'b0, h_q};
	assign no_more_tex = nt_q >= NT_W'(MAX_TEXTURES);

	// Cursor advance after a placement, saturating at the top of the range.
	logic [15:0] cx_adv;
	logic [14:0] cx_after;

	assign cx_adv   = {1'b0, cx_q} + {5'd0, {1'b0, box_q} + {3'd0, pad_pixels_q}};
	assign cx_after = cx_adv[15] ? 15'h7FFF : cx_adv[14:0];

	logic [NT_W-1:0] index_w;
	assign index_w = nt_q - NT_W'(1);

	// The finished result moves into the output register once that register is
	// free or is being emptied in the same cycle.
	logic out_load;
	assign out_load = (state_q == S_FINISH) && (!out_valid_q || !out_stall);

	assign in_stall       = (state_q != S_IDLE);
	assign cfg_ready      = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign texture_index  = texture_index_q;
	assign x_position     = x_position_q;
	assign y_position     = y_position_q;
	assign texture_width  = texture_width_q;
	assign texture_height = texture_height_q;
	assign new_texture    = new_texture_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			glyph_count_q    <= gasp_pkg::RST_GLYPH_COUNT;
			cell_width_q     <= gasp_pkg::RST_CELL_WIDTH;
			cell_height_q    <= gasp_pkg::RST_CELL_HEIGHT;
			pad_pixels_q     <= gasp_pkg::RST_PAD_PIXELS;
			max_tex_q        <= gasp_pkg::RST_MAX_TEX;
			cursor_x_q       <= '0;
			cursor_y_q       <= '0;
			textures_open_q  <= '0;
			current_width_q  <= '0;
			current_height_q <= '0;
			remaining_q      <= gasp_pkg::RST_GLYPH_COUNT;
			ok_q             <= 1'b0;
			box_q            <= '0;
			cx_q             <= '0;
			cy_q             <= '0;
			nt_q             <= '0;
			w_q              <= '0;
			h_q              <= '0;
			opened_q         <= 1'b0;
			first_q          <= 1'b0;
			stat_q           <= gasp_pkg::ST_PLACED;
			v_q              <= '0;
			rem_q            <= '0;
			quo_q            <= '0;
			den_q            <= '0;
			cnt_q            <= '0;
			out_valid_q      <= 1'b0;
			status_q         <= gasp_pkg::ST_PLACED;
			texture_index_q  <= '0;
			x_position_q     <= '0;
			y_position_q     <= '0;
			texture_width_q  <= '0;
			texture_height_q <= '0;
			new_texture_q    <= 1'b0;
		end else begin
			// A new result takes the output register; otherwise the result
			// leaves once the consumer takes it.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Writing glyph_count also restarts the remaining count.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gasp_pkg::REG_GLYPH_COUNT: begin
						glyph_count_q <= cfg_data;
						remaining_q   <= cfg_data;
					end
					gasp_pkg::REG_CELL_WIDTH:  cell_width_q  <= cfg_data[9:0];
					gasp_pkg::REG_CELL_HEIGHT: cell_height_q <= cfg_data[9:0];
					gasp_pkg::REG_PAD_PIXELS:  pad_pixels_q  <= cfg_data[7:0];
					gasp_pkg::REG_MAX_TEX:     max_tex_q     <= cfg_data[14:0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ok_q     <= glyph_ok;
						box_q    <= glyph_box_width;
						cx_q     <= cursor_x_q;
						cy_q     <= cursor_y_q;
						nt_q     <= textures_open_q;
						w_q      <= current_width_q;
						h_q      <= current_height_q;
						opened_q <= 1'b0;
						first_q  <= 1'b0;
						stat_q   <= gasp_pkg::ST_PLACED;
						state_q  <= S_EVAL;
					end
				end

				S_EVAL: begin
					if (!ok_q) begin
						stat_q  <= gasp_pkg::ST_LOAD_FAIL;
						state_q <= S_FINISH;
					end else if (nt_q == '0) begin
						// The very first glyph opens a texture and starts at the
						// padded corner; the row check follows the sizing.
						cx_q    <= {7'd0, pad_pixels_q};
						cy_q    <= {7'd0, pad_pixels_q};
						first_q <= 1'b1;
						state_q <= S_MUL_W;
					end else begin
						state_q <= S_ROW;
					end
				end

				S_ROW: begin
					if (row_full) begin
						cx_q <= {7'd0, pad_pixels_q};
						cy_q <= cy_next;
						if (tex_full) begin
							if (no_more_tex) begin
								stat_q  <= gasp_pkg::ST_NO_TEXTURE;
								state_q <= S_FINISH;
							end else begin
								first_q <= 1'b0;
								state_q <= S_MUL_W;
							end
						end else begin
							state_q <= S_FINISH;
						end
					end else begin
						state_q <= S_FINISH;
					end
				end

				S_MUL_W: begin
					v_q     <= {1'b0, mul_p} + {19'd0, two_pad};
					state_q <= S_CLAMP_W;
				end

				S_CLAMP_W: begin
					w_q     <= gasp_pkg::clamp_size(v_q, max_tex_q);
					state_q <= S_DIV_INIT;
				end

				S_DIV_INIT: begin
					// Columns = usable width over cell width; no usable width
					// gives a zero quotient, which becomes one column below.
					if (w_q > {6'd0, two_pad}) begin
						quo_q <= {1'b0, w_q - {6'd0, two_pad}};
					end else begin
						quo_q <= '0;
					end
					den_q   <= (cell_width_q == '0) ? 15'd1 : {5'd0, cell_width_q};
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV_COLS;
				end

				S_DIV_COLS: begin
					rem_q <= rem_next;
					quo_q <= {quo_q[14:0], div_ge};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= S_NEXT_DIV;
					end
				end

				S_NEXT_DIV: begin
					den_q   <= (quo_q == '0) ? 15'd1 : quo_q[14:0];
					quo_q   <= glyph_count_q;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV_ROWS;
				end

				S_DIV_ROWS: begin
					rem_q <= rem_next;
					quo_q <= {quo_q[14:0], div_ge};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= S_MUL_H;
					end
				end

				S_MUL_H: begin
					v_q     <= {1'b0, mul_p};
					state_q <= S_CLAMP_H;
				end

				S_CLAMP_H: begin
					h_q      <= gasp_pkg::clamp_size(v_q, max_tex_q);
					nt_q     <= nt_q + NT_W'(1);
					opened_q <= 1'b1;
					if (first_q) begin
						state_q <= S_ROW;
					end else begin
						cy_q    <= {7'd0, pad_pixels_q};
						state_q <= S_FINISH;
					end
				end

				S_FINISH: begin
					if (out_load) begin
						status_q <= stat_q;
						if (stat_q == gasp_pkg::ST_PLACED) begin
							texture_index_q  <= 8'(index_w);
							x_position_q     <= cx_q[13:0];
							y_position_q     <= cy_q[13:0];
							texture_width_q  <= w_q;
							texture_height_q <= h_q;
							new_texture_q    <= opened_q;
							cursor_x_q       <= cx_after;
							cursor_y_q       <= cy_q;
							textures_open_q  <= nt_q;
							current_width_q  <= w_q;
							current_height_q <= h_q;
							if (remaining_q != '0) begin
								remaining_q <= remaining_q - 16'd1;
							end
						end else begin
							// A failed request reports the committed size and
							// leaves all state untouched.
							texture_index_q  <= '0;
							x_position_q     <= '0;
							y_position_q     <= '0;
							texture_width_q  <= current_width_q;
							texture_height_q <= current_height_q;
							new_texture_q    <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sim/tb_glyph_atlas_shelf_packer_core.sv
`timescale 1ns / 100ps

// Testbench for the glyph atlas shelf packer core.
//
// The bench keeps its own model of the packer: the shelf cursor, the number of
// textures opened so far, the size of the current texture, the glyphs still
// remaining, and a copy of the five setup registers. Every request that the core
// accepts is run through that model at the accepting edge. The predicted
// placement goes into a queue, and a monitor pops one entry for each result
// that leaves the core and compares it field by field.
module tb_glyph_atlas_shelf_packer_core;

	localparam int MAX_TEX = 256;

	// The largest value that the cursor registers can hold.
	localparam int CURSOR_MAX = 32767;

	// What one glyph request is expected to produce.
	typedef struct packed {
		gasp_pkg::status_t status;
		logic [7:0]        tex_index;
		logic [13:0]       x_pos;
		logic [13:0]       y_pos;
		logic [14:0]       width;
		logic [14:0]       height;
		logic              fresh;
	} glyph_place_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic                           glyph_ok;
	logic [9:0]                     glyph_box_width;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [1:0]                     status;
	logic [7:0]                     texture_index;
	logic [13:0]                    x_position;
	logic [13:0]                    y_position;
	logic [14:0]                    texture_width;
	logic [14:0]                    texture_height;
	logic                           new_texture;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [gasp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0]                    cfg_data;

	glyph_atlas_shelf_packer_core #(
		.MAX_TEXTURES(MAX_TEX)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.glyph_ok       (glyph_ok),
		.glyph_box_width(glyph_box_width),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.texture_index  (texture_index),
		.x_position     (x_position),
		.y_position     (y_position),
		.texture_width  (texture_width),
		.texture_height (texture_height),
		.new_texture    (new_texture),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	// Mirror of the setup registers.
	int r_gc, r_cw, r_ch, r_pad, r_max;

	// Mirror of the packer state.
	int pk_cx, pk_cy, pk_open, pk_w, pk_h, pk_left;

	glyph_place_t placements_due[$];
	int           mismatch_count;

	// When clear, neither the request side nor the result side holds back.
	bit idle_en;
	int rx_hold = 0;

	// ------------------------------------------------------------------
	// Packer model
	// ------------------------------------------------------------------

	// Smallest power of two that is not below v; zero maps to one.
	function automatic longint ceil_pow2(input longint v);
		longint r;
		r = 1;
		while (r < v)
			r = r << 1;
		return r;
	endfunction

	function automatic int sat15(input int v);
		return (v > CURSOR_MAX) ? CURSOR_MAX : v;
	endfunction

	// Size a new texture. The width covers every glyph still to come in one
	// row, the height covers enough rows for the whole face, and both edges
	// are limited to the largest allowed texture.
	function automatic void size_atlas(output int w, output int h);
		longint two_pad, span, cols, rows_px;
		two_pad = 2 * longint'(r_pad);
		span = ceil_pow2(longint'(pk_left) * r_cw + two_pad);
		if (span > r_max)
			span = r_max;
		cols = (span > two_pad) ? (span - two_pad) / ((r_cw != 0) ? r_cw : 1) : 0;
		if (cols == 0)
			cols = 1;
		rows_px = ceil_pow2((r_gc / cols + 1) * r_ch);
		if (rows_px > r_max)
			rows_px = r_max;
		w = int'(span);
		h = int'(rows_px);
	endfunction

	// Place one glyph and return what the core must report for it. The model
	// state moves on only when the glyph is really placed.
	function automatic glyph_place_t place_glyph(input logic ok, input logic [9:0] box);
		int                cx, cy, n_open, w, h;
		logic              fresh;
		gasp_pkg::status_t st;
		glyph_place_t      res;
		cx = pk_cx;
		cy = pk_cy;
		n_open = pk_open;
		w = pk_w;
		h = pk_h;
		fresh = 1'b0;
		st = gasp_pkg::ST_PLACED;
		if (!ok) begin
			st = gasp_pkg::ST_LOAD_FAIL;
		end else begin
			// The very first glyph always opens a texture and starts at the padding.
			if (n_open == 0) begin
				size_atlas(w, h);
				n_open = 1;
				fresh = 1'b1;
				cx = r_pad;
				cy = r_pad;
			end
			// Past the end of the shelf: start a new row, and a new texture when
			// the row no longer fits below.
			if (cx > w - r_cw) begin
				cx = r_pad;
				cy = sat15(cy + r_ch);
				if (cy > h - r_ch) begin
					if (n_open >= MAX_TEX) begin
						st = gasp_pkg::ST_NO_TEXTURE;
					end else begin
						size_atlas(w, h);
						n_open++;
						fresh = 1'b1;
						cy = r_pad;
					end
				end
			end
		end
		res.status = st;
		if (st != gasp_pkg::ST_PLACED) begin
			res.tex_index = '0;
			res.x_pos = '0;
			res.y_pos = '0;
			res.width = pk_w[14:0];
			res.height = pk_h[14:0];
			res.fresh = 1'b0;
		end else begin
			res.tex_index = 8'(n_open - 1);
			res.x_pos = cx[13:0];
			res.y_pos = cy[13:0];
			res.width = w[14:0];
			res.height = h[14:0];
			res.fresh = fresh;
			pk_cx = sat15(cx + int'(box) + r_pad);
			pk_cy = cy;
			pk_open = n_open;
			pk_w = w;
			pk_h = h;
			if (pk_left > 0)
				pk_left--;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Send one glyph request. The task is entered and left at a falling edge.
	// Valid stays high after acceptance so that back-to-back requests never
	// lower and raise it within one step; finish_requests lowers it.
	task automatic send_glyph(input logic ok, input logic [9:0] box);
		glyph_place_t want;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		glyph_ok <= ok;
		glyph_box_width <= box;
		do @(posedge clk); while (in_stall);
		want = place_glyph(ok, box);
		placements_due.insert(placements_due.size(), want);
		@(negedge clk);
	endtask

	// Stop sending and wait until every pending placement has come back. Each
	// request gives exactly one result, so the core is idle after this.
	task automatic finish_requests();
		in_valid <= 1'b0;
		do @(negedge clk); while (placements_due.size() != 0);
	endtask

	// One register write; cfg_valid is left high for the next write.
	task automatic write_reg(input logic [gasp_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			gasp_pkg::REG_GLYPH_COUNT: begin
				// Loading the glyph count also restarts the remaining count.
				r_gc = int'(data);
				pk_left = int'(data);
			end
			gasp_pkg::REG_CELL_WIDTH:  r_cw = int'(data[9:0]);
			gasp_pkg::REG_CELL_HEIGHT: r_ch = int'(data[9:0]);
			gasp_pkg::REG_PAD_PIXELS:  r_pad = int'(data[7:0]);
			gasp_pkg::REG_MAX_TEX:     r_max = int'(data[14:0]);
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Load all five registers. Only called while no request is pending.
	task automatic write_settings(input int gc, input int cw, input int ch, input int pad,
			input int mx);
		write_reg(gasp_pkg::REG_GLYPH_COUNT, 16'(gc));
		write_reg(gasp_pkg::REG_CELL_WIDTH, 16'(cw));
		write_reg(gasp_pkg::REG_CELL_HEIGHT, 16'(ch));
		write_reg(gasp_pkg::REG_PAD_PIXELS, 16'(pad));
		write_reg(gasp_pkg::REG_MAX_TEX, 16'(mx));
		cfg_valid <= 1'b0;
	endtask

	// A value in [lo, hi] that lands on either end half of the time.
	function automatic int pick(input int lo, input int hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return int'($urandom_range(hi, lo));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Holds results back in bursts of random length.
	always @(negedge clk) begin
		if (!idle_en) begin
			rx_hold <= 0;
			out_stall <= 1'b0;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			rx_hold <= int'($urandom_range(1, 17)) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t ns: MISMATCH %s", $time, what);
	endtask

	always @(posedge clk) begin : check_results
		glyph_place_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (placements_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result, status %0d index %0d",
					status, texture_index));
			end else begin
				want = placements_due.pop_front();
				if (status !== want.status || texture_index !== want.tex_index ||
						x_position !== want.x_pos || y_position !== want.y_pos ||
						texture_width !== want.width || texture_height !== want.height ||
						new_texture !== want.fresh)
					report_mismatch({
						$sformatf("got st %0d tex %0d at (%0d,%0d) %0dx%0d new %0b",
							status, texture_index, x_position, y_position,
							texture_width, texture_height, new_texture),
						$sformatf(", want %0d %0d (%0d,%0d) %0dx%0d %0b",
							want.status, want.tex_index, want.x_pos, want.y_pos,
							want.width, want.height, want.fresh)});
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// The first glyph of the run opens a texture, and because the padding is
	// wider than the tiny texture, the row check opens a second one at once.
	// A single-glyph face also runs the remaining count down to zero, and the
	// padding leaves no room for a column, so the column count is forced up.
	task automatic test_double_open();
		write_settings(1, 16, 16, 255, 64);
		send_glyph(1'b1, 10'd0);
		send_glyph(1'b0, 10'd1023);
		send_glyph(1'b1, 10'd1023);
		send_glyph(1'b1, 10'd512);
		finish_requests();
	endtask

	// With huge cells and a small texture every glyph opens a texture. Once the
	// face is used up and the padding is zero, the next texture sizes from an
	// empty sum, which gives a texture one pixel wide.
	task automatic test_remaining_exhausted();
		write_settings(1, 1023, 1023, 0, 64);
		send_glyph(1'b1, 10'd341);
		send_glyph(1'b1, 10'd682);
		send_glyph(1'b0, 10'd0);
		send_glyph(1'b1, 10'd1023);
		finish_requests();
	endtask

	// Largest face, widest padding and the largest texture, with narrow cells
	// that give thousands of columns.
	task automatic test_large_extremes();
		write_settings(65535, 1, 1023, 255, 16384);
		send_glyph(1'b1, 10'd1023);
		send_glyph(1'b1, 10'd0);
		send_glyph(1'b1, 10'd1023);
		send_glyph(1'b0, 10'd1023);
		send_glyph(1'b1, 10'd1023);
		send_glyph(1'b1, 10'd1);
		finish_requests();
	endtask

	// Back to the power-on register values.
	task automatic test_defaults_restored();
		write_settings(gasp_pkg::RST_GLYPH_COUNT, gasp_pkg::RST_CELL_WIDTH,
			gasp_pkg::RST_CELL_HEIGHT, gasp_pkg::RST_PAD_PIXELS, gasp_pkg::RST_MAX_TEX);
		send_glyph(1'b1, 10'd1023);
		send_glyph(1'b1, 10'd0);
		send_glyph(1'b0, 10'd512);
		send_glyph(1'b1, 10'd1023);
		send_glyph(1'b1, 10'd1023);
		send_glyph(1'b1, 10'd1023);
		finish_requests();
	endtask

	// Random glyphs under a series of register settings. Textures are never
	// given back, so once many are open the settings turn to large textures
	// with small cells, and a round stops early to leave room for the last test.
	task automatic test_random_settings();
		int         round, n;
		logic       ok;
		logic [9:0] box;
		for (round = 0; round < 6; round++) begin
			if (round == 0)
				write_settings(gasp_pkg::RST_GLYPH_COUNT, gasp_pkg::RST_CELL_WIDTH,
					gasp_pkg::RST_CELL_HEIGHT, gasp_pkg::RST_PAD_PIXELS,
					gasp_pkg::RST_MAX_TEX);
			else if (pk_open > 100)
				write_settings($urandom_range(65535, 1000), $urandom_range(8, 1),
					$urandom_range(8, 1), $urandom_range(7, 0), 16384);
			else if (round == 5)
				write_settings(65535, 1023, 1023, 255, 16384);
			else
				write_settings(pick(1, 65535),
					$urandom_range(0, 1) ? pick(1, 64) : pick(1, 1023),
					$urandom_range(0, 1) ? pick(1, 64) : pick(1, 1023),
					pick(0, 255), pick(64, 16384));
			for (n = 0; n < 130 && pk_open < 230; n++) begin
				ok = ($urandom_range(0, 7) != 0);
				case ($urandom_range(0, 7))
					0:       box = 10'd0;
					1:       box = 10'd1023;
					2, 3:    box = 10'($urandom_range(31, 0));
					default: box = 10'($urandom_range(1023, 0));
				endcase
				send_glyph(ok, box);
			end
			finish_requests();
		end
	endtask

	// Open textures until every one is used, then keep asking: each further
	// glyph that needs a texture is refused and leaves the state alone. This
	// runs last and with no idling on either side.
	task automatic test_out_of_textures();
		idle_en = 1'b0;
		write_settings(65535, 1023, 1023, 255, 64);
		// While the current texture is still large, the widest boxes close its
		// rows fastest; after that every glyph opens a texture of its own.
		while (pk_open < MAX_TEX)
			send_glyph(1'b1, (pk_w > 64) ? 10'd1023 : 10'($urandom_range(1023, 0)));
		send_glyph(1'b1, 10'd0);
		send_glyph(1'b0, 10'd1023);
		send_glyph(1'b1, 10'd1023);
		send_glyph(1'b1, 10'($urandom_range(1023, 0)));
		finish_requests();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		glyph_ok = 1'b0;
		glyph_box_width = '0;
		cfg_valid = 1'b0;
		cfg_index = gasp_pkg::REG_GLYPH_COUNT;
		cfg_data = '0;
		idle_en = 1'b1;
		mismatch_count = 0;

		// Power-on state of the model.
		r_gc = int'(gasp_pkg::RST_GLYPH_COUNT);
		r_cw = int'(gasp_pkg::RST_CELL_WIDTH);
		r_ch = int'(gasp_pkg::RST_CELL_HEIGHT);
		r_pad = int'(gasp_pkg::RST_PAD_PIXELS);
		r_max = int'(gasp_pkg::RST_MAX_TEX);
		pk_cx = 0;
		pk_cy = 0;
		pk_open = 0;
		pk_w = 0;
		pk_h = 0;
		pk_left = r_gc;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The double opening can only happen on the first glyph of the run.
		test_double_open();
		test_remaining_exhausted();
		test_large_extremes();
		test_defaults_restored();
		test_random_settings();
		test_out_of_textures();

		// Leave time for any stray result to show up.
		repeat (40) @(negedge clk);
		if (mismatch_count == 0 && placements_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// A request is slowest when it opens textures, and idling on both sides adds
	// to that; this limit leaves ample room over the slowest correct run.
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
